// ===== rtl/core/awpg_pkg.sv =====
// Shared constants, types and the quarter-wave sine builder for the aurora pixel generator.
`default_nettype none

package awpg_pkg;

   // Beat field widths
   localparam int PX_W = 10;
   localparam int PY_W = 10;
   localparam int T_W  = 18;
   localparam int CH_W = 8;

   // Default frame size
   localparam int FRAME_WIDTH_DEF  = 1024;
   localparam int FRAME_HEIGHT_DEF = 768;

   // Coordinate normalisation: (coord << 16) / frame size
   localparam int COORD_FRAC = 16;

   // Wave phase: units of 2^-17 half turns, modulo one full turn
   localparam int PHASE_W   = 18;
   localparam int SIN_IDX_W = 10;
   localparam int QSIN_DEPTH = 257;
   localparam int QSIN_IDX_W = 9;
   localparam int QSIN_W     = 15;
   localparam int WAVE_W     = 16;

   // Intensity: (sum + 98301) * 65536 / 196602 == (sum + 98301) * 32768 / 98301
   localparam int INTEN_OFFSET = 98301;
   localparam int INTEN_DIV    = 98301;
   localparam int INTEN_SHIFT  = 15;
   localparam int U_W          = 18;
   localparam int Q16_W        = 17;  // Q0.16 that may reach 1.0

   // Band thresholds, Q0.16
   localparam int THR_HIGH = 45875;
   localparam int THR_MID  = 26214;
   localparam int THR_LOW  = 6553;

   // Lerp factor: (v - thr) * 333 / 25600, Q0.8
   localparam int DIFF_W    = 16;
   localparam int LERP_MUL  = 333;
   localparam int LERP_DIV  = 25600;
   localparam int LERP_NUM_W = 25;
   localparam int F_MAX     = 255;

   // Palette
   localparam logic [23:0] COL_GREEN  = 24'h00FF44;
   localparam logic [23:0] COL_PURPLE = 24'h8844FF;
   localparam logic [23:0] COL_BLUE   = 24'h0044FF;
   localparam logic [23:0] COL_NIGHT  = 24'h000011;

   // Pipeline depth, one bit of valid per stage
   localparam int STAGES = 17;

   typedef enum logic [1:0] {
      BAND_NONE,
      BAND_LOW,
      BAND_MID,
      BAND_HIGH
   } band_type;

   typedef struct packed {
      logic [STAGES-1:0] load;
      logic              in_ready;
      logic              out_valid;
   } pipe_ctl_type;

   // Width of floor(num / div) for a num_w-bit numerator
   function automatic int quo_width(input int num_w, input int div);
      return num_w - $clog2(div) + 1;
   endfunction

   // sin(pi/2 * k/256), amplitude 32767, via Q30 Taylor series (terms to x^17)
   function automatic logic [QSIN_W-1:0] quarter_sine(input int k);
      logic [63:0] x;
      logic [63:0] term;
      longint      sum;
      logic [63:0] scaled;
      x    = (64'(k) * 64'd3373259426) >> 9;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / 64'((2 * n) * (2 * n + 1));
         if ((n & 1) != 0) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > longint'(64'd1073741824)) begin
         sum = longint'(64'd1073741824);
      end
      scaled = (64'(sum) * 64'd32767 + 64'd536870912) >> 30;
      return scaled[QSIN_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/awpg_if.sv =====
// Pixel request and colour response channel interfaces.
`default_nettype none

interface awpg_req_if;
   logic                        valid;
   logic                        ready;
   logic [awpg_pkg::PX_W-1:0]   pixel_x;
   logic [awpg_pkg::PY_W-1:0]   pixel_y;
   logic [awpg_pkg::T_W-1:0]    time_phase;

   modport source (output valid, output pixel_x, output pixel_y, output time_phase,
                   input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, input time_phase,
                   output ready);
endinterface

interface awpg_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [awpg_pkg::CH_W-1:0]   red;
   logic [awpg_pkg::CH_W-1:0]   green;
   logic [awpg_pkg::CH_W-1:0]   blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/awpg_cdiv.sv =====
// Three-stage divide by a constant: reciprocal multiply, back-multiply, one correction step.
`default_nettype none

module awpg_cdiv #(
   parameter int NUM_W   = 26,
   parameter int DIVISOR = 1024,
   localparam int QUO_W  = awpg_pkg::quo_width(NUM_W, DIVISOR)
) (
   input  wire logic              clock,
   input  wire logic [2:0]        load,
   input  wire logic [NUM_W-1:0]  num,
   output logic      [QUO_W-1:0]  quo
);

   localparam int PROD_W = NUM_W + QUO_W;
   localparam logic [63:0] RECIP_FULL = (64'd1 << NUM_W) / 64'(DIVISOR);
   localparam logic [QUO_W-1:0] RECIP = RECIP_FULL[QUO_W-1:0];
   localparam logic [NUM_W-1:0] DIV_N = NUM_W'(DIVISOR);

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [NUM_W-1:0]  num0_ff;
   logic [QUO_W-1:0]  q1_ff, q1_in;
   logic [NUM_W-1:0]  qd1_ff, qd1_in;
   logic [NUM_W-1:0]  num1_ff;
   logic [NUM_W-1:0]  rem;
   logic [QUO_W-1:0]  quo_ff, quo_in;

   // estimate is floor(num/D) or one below it
   assign prod_in = PROD_W'(num) * PROD_W'(RECIP);
   assign q1_in   = prod_ff[PROD_W-1:NUM_W];
   assign qd1_in  = NUM_W'(q1_in * DIV_N);
   assign rem     = num1_ff - qd1_ff;
   assign quo_in  = q1_ff + QUO_W'(rem >= DIV_N);

   always_ff @(posedge clock) begin
      if (load[0]) begin
         prod_ff <= prod_in;
         num0_ff <= num;
      end
      if (load[1]) begin
         q1_ff   <= q1_in;
         qd1_ff  <= qd1_in;
         num1_ff <= num0_ff;
      end
      if (load[2]) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/core/awpg_wave.sv =====
// Two-stage sine lookup: fold phase index to a quarter wave, then read and sign it.
`default_nettype none

module awpg_wave (
   input  wire logic                                  clock,
   input  wire logic [1:0]                            load,
   input  wire logic [awpg_pkg::SIN_IDX_W-1:0]        idx,
   output logic signed [awpg_pkg::WAVE_W-1:0]         wave
);

   logic [awpg_pkg::QSIN_W-1:0]     qsin_rom [awpg_pkg::QSIN_DEPTH];
   logic [awpg_pkg::QSIN_IDX_W-1:0] fold_ff, fold_in;
   logic                            neg_ff;
   logic [awpg_pkg::QSIN_W-1:0]     mag;
   logic signed [awpg_pkg::WAVE_W-1:0] wave_ff, wave_in;

   for (genvar k = 0; k < awpg_pkg::QSIN_DEPTH; k++) begin : g_rom
      assign qsin_rom[k] = awpg_pkg::quarter_sine(k);
   end

   // odd quadrants run the quarter wave backwards
   assign fold_in = idx[8] ? (awpg_pkg::QSIN_IDX_W'(256) - {1'b0, idx[7:0]})
                           : {1'b0, idx[7:0]};
   assign mag     = qsin_rom[fold_ff];
   assign wave_in = neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

   always_ff @(posedge clock) begin
      if (load[0]) begin
         fold_ff <= fold_in;
         neg_ff  <= idx[9];
      end
      if (load[1]) begin
         wave_ff <= wave_in;
      end
   end

   assign wave = wave_ff;

endmodule

`default_nettype wire

// ===== rtl/core/awpg_ctl.sv =====
// Pipeline valid bits and per-stage load enables with bubble collapse.
`default_nettype none

module awpg_ctl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire logic                   out_ready,
   output awpg_pkg::pipe_ctl_type      ctl
);

   localparam int N = awpg_pkg::STAGES;

   logic [N-1:0] valid_ff, valid_in;
   logic [N-1:0] load;

   // a stage may move when output drains or any slot at or after it is empty
   always_comb begin
      for (int k = 0; k < N; k++) begin
         load[k] = out_ready || (((~valid_ff) >> k) != '0);
      end
      valid_in[0] = load[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < N; k++) begin
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.load      = load;
   assign ctl.in_ready  = load[0];
   assign ctl.out_valid = valid_ff[N-1];

endmodule

`default_nettype wire

// ===== rtl/core/aurora_wave_pixel_generator_unit.sv =====
// Top level of the aurora pixel generator: seventeen-stage colour pipeline.
// Throughput: one pixel per cycle; a stalled rsp holds the output register
// while earlier stages keep filling any bubbles ahead of it.
// Reset: clears the stage valid bits only; datapath registers are not reset.
`default_nettype none

module aurora_wave_pixel_generator_unit #(
   parameter int FRAME_WIDTH  = awpg_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = awpg_pkg::FRAME_HEIGHT_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   awpg_req_if.sink    req_ch,
   awpg_rsp_if.source  rsp_ch
);

   // Stage map
   //  0..2   nx, ny = (coord << 16) / frame size       (constant dividers)
   //  3      three phase indices, d = 1 - ny (sat)
   //  4..5   sine fold + table read; att = d^2 at 4
   //  6      u = w1 + w2 + w3 + offset
   //  7..9   intensity = (u << 15) / 98301
   //  10     v = intensity * att
   //  11     band pick, distance above threshold
   //  12     distance * 333
   //  13..15 lerp factor = product / 25600
   //  16     saturate factor, blend, output register
   localparam int ST_PHASE = 3;
   localparam int ST_ATT   = 4;
   localparam int ST_WAVE  = 4;
   localparam int ST_SUM   = 6;
   localparam int ST_INTEN = 7;
   localparam int ST_V     = 10;
   localparam int ST_BAND  = 11;
   localparam int ST_PROD  = 12;
   localparam int ST_LERP  = 13;
   localparam int ST_OUT   = 16;

   localparam int COORD_NUM_W = awpg_pkg::PX_W + awpg_pkg::COORD_FRAC;
   localparam int NX_W = awpg_pkg::quo_width(COORD_NUM_W, FRAME_WIDTH);
   localparam int NY_W = awpg_pkg::quo_width(COORD_NUM_W, FRAME_HEIGHT);
   localparam int INTEN_NUM_W = awpg_pkg::U_W + awpg_pkg::INTEN_SHIFT;
   localparam int INTEN_W = awpg_pkg::quo_width(INTEN_NUM_W, awpg_pkg::INTEN_DIV);
   localparam int F_Q_W = awpg_pkg::quo_width(awpg_pkg::LERP_NUM_W, awpg_pkg::LERP_DIV);
   localparam int PW = awpg_pkg::PHASE_W;
   localparam int QW = awpg_pkg::Q16_W;

   awpg_pkg::pipe_ctl_type ctl;

   // ---------------------------------------------------------------- control
   awpg_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .out_ready (rsp_ch.ready),
      .ctl       (ctl)
   );

   assign req_ch.ready = ctl.in_ready;
   assign rsp_ch.valid = ctl.out_valid;

   // ------------------------------------------------- stages 0..2: normalise
   logic [awpg_pkg::T_W-1:0] t_pipe_ff [3];
   logic [NX_W-1:0]          nx;
   logic [NY_W-1:0]          ny;

   awpg_cdiv #(.NUM_W(COORD_NUM_W), .DIVISOR(FRAME_WIDTH)) u_div_x (
      .clock (clock),
      .load  (ctl.load[2:0]),
      .num   ({req_ch.pixel_x, awpg_pkg::COORD_FRAC'(0)}),
      .quo   (nx)
   );

   awpg_cdiv #(.NUM_W(COORD_NUM_W), .DIVISOR(FRAME_HEIGHT)) u_div_y (
      .clock (clock),
      .load  (ctl.load[2:0]),
      .num   ({req_ch.pixel_y, awpg_pkg::COORD_FRAC'(0)}),
      .quo   (ny)
   );

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         t_pipe_ff[0] <= req_ch.time_phase;
      end
      for (int k = 1; k < 3; k++) begin
         if (ctl.load[k]) begin
            t_pipe_ff[k] <= t_pipe_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------ stage 3: phases
   // phases wrap at one full turn, so only the low 18 bits of nx, ny count
   logic [PW-1:0] nx_w, ny_w, t_w;
   logic [PW-1:0] p1, p2, p3;
   logic [awpg_pkg::SIN_IDX_W-1:0] idx1_ff, idx2_ff, idx3_ff;
   logic [QW-1:0] d_ff, d_in;
   logic          ny_off_frame;

   assign nx_w = PW'(nx);
   assign ny_w = PW'(ny);
   assign t_w  = t_pipe_ff[2];
   assign p1 = PW'(ny_w * PW'(16)) + PW'(nx_w * PW'(4)) + PW'(t_w * PW'(4));
   assign p2 = PW'(ny_w * PW'(24)) + PW'(nx_w * PW'(3)) + PW'(t_w * PW'(3));
   assign p3 = PW'(ny_w * PW'(12)) + PW'(nx_w * PW'(6)) + PW'(t_w * PW'(6));

   // below the frame the fade term is zero
   assign ny_off_frame = (32'(ny) >= 32'd65536);
   assign d_in = ny_off_frame ? '0 : QW'(32'd65536 - 32'(ny));

   always_ff @(posedge clock) begin
      if (ctl.load[ST_PHASE]) begin
         idx1_ff <= p1[PW-1:8];
         idx2_ff <= p2[PW-1:8];
         idx3_ff <= p3[PW-1:8];
         d_ff    <= d_in;
      end
   end

   // ------------------------------------------ stages 4..5: sines, fade term
   logic signed [awpg_pkg::WAVE_W-1:0] w1, w2, w3;
   logic [2*QW-1:0] dd;
   logic [QW-1:0]   att_pipe_ff [6];

   awpg_wave u_wave1 (
      .clock (clock), .load (ctl.load[ST_WAVE+1:ST_WAVE]), .idx (idx1_ff), .wave (w1)
   );
   awpg_wave u_wave2 (
      .clock (clock), .load (ctl.load[ST_WAVE+1:ST_WAVE]), .idx (idx2_ff), .wave (w2)
   );
   awpg_wave u_wave3 (
      .clock (clock), .load (ctl.load[ST_WAVE+1:ST_WAVE]), .idx (idx3_ff), .wave (w3)
   );

   assign dd = (2*QW)'(d_ff) * (2*QW)'(d_ff);

   // att rides along until the intensity is ready at stage 10
   always_ff @(posedge clock) begin
      if (ctl.load[ST_ATT]) begin
         att_pipe_ff[0] <= dd[QW+15:16];
      end
      for (int k = 1; k < 6; k++) begin
         if (ctl.load[ST_ATT+k]) begin
            att_pipe_ff[k] <= att_pipe_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------- stage 6: sum
   logic signed [awpg_pkg::U_W:0] s_sum;
   logic [awpg_pkg::U_W-1:0]      u_ff, u_in;

   assign s_sum = (awpg_pkg::U_W+1)'(w1) + (awpg_pkg::U_W+1)'(w2)
                + (awpg_pkg::U_W+1)'(w3) + (awpg_pkg::U_W+1)'(awpg_pkg::INTEN_OFFSET);
   assign u_in  = s_sum[awpg_pkg::U_W-1:0];

   always_ff @(posedge clock) begin
      if (ctl.load[ST_SUM]) begin
         u_ff <= u_in;
      end
   end

   // ------------------------------------------------ stages 7..9: intensity
   logic [INTEN_W-1:0] inten;

   awpg_cdiv #(.NUM_W(INTEN_NUM_W), .DIVISOR(awpg_pkg::INTEN_DIV)) u_div_inten (
      .clock (clock),
      .load  (ctl.load[ST_INTEN+2:ST_INTEN]),
      .num   ({u_ff, awpg_pkg::INTEN_SHIFT'(0)}),
      .quo   (inten)
   );

   // ------------------------------------------------------ stage 10: value
   logic [2*QW-1:0] va;
   logic [QW-1:0]   v_ff;

   assign va = (2*QW)'(inten) * (2*QW)'(att_pipe_ff[5]);

   always_ff @(posedge clock) begin
      if (ctl.load[ST_V]) begin
         v_ff <= va[QW+15:16];
      end
   end

   // ------------------------------------------------------- stage 11: band
   // a value equal to a threshold belongs to the band below
   awpg_pkg::band_type          band_in;
   awpg_pkg::band_type          band_pipe_ff [5];
   logic [awpg_pkg::DIFF_W-1:0] diff_ff, diff_in;

   always_comb begin
      if (v_ff > QW'(awpg_pkg::THR_HIGH)) begin
         band_in = awpg_pkg::BAND_HIGH;
         diff_in = awpg_pkg::DIFF_W'(v_ff - QW'(awpg_pkg::THR_HIGH));
      end else if (v_ff > QW'(awpg_pkg::THR_MID)) begin
         band_in = awpg_pkg::BAND_MID;
         diff_in = awpg_pkg::DIFF_W'(v_ff - QW'(awpg_pkg::THR_MID));
      end else if (v_ff > QW'(awpg_pkg::THR_LOW)) begin
         band_in = awpg_pkg::BAND_LOW;
         diff_in = awpg_pkg::DIFF_W'(v_ff - QW'(awpg_pkg::THR_LOW));
      end else begin
         band_in = awpg_pkg::BAND_NONE;
         diff_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[ST_BAND]) begin
         band_pipe_ff[0] <= band_in;
         diff_ff         <= diff_in;
      end
      for (int k = 1; k < 5; k++) begin
         if (ctl.load[ST_BAND+k]) begin
            band_pipe_ff[k] <= band_pipe_ff[k-1];
         end
      end
   end

   // ------------------------------------------------ stage 12: lerp product
   logic [awpg_pkg::LERP_NUM_W-1:0] lprod_ff, lprod_in;

   assign lprod_in = awpg_pkg::LERP_NUM_W'(32'(diff_ff) * 32'(awpg_pkg::LERP_MUL));

   always_ff @(posedge clock) begin
      if (ctl.load[ST_PROD]) begin
         lprod_ff <= lprod_in;
      end
   end

   // ---------------------------------------------- stages 13..15: lerp factor
   logic [F_Q_W-1:0] f_q;

   awpg_cdiv #(.NUM_W(awpg_pkg::LERP_NUM_W), .DIVISOR(awpg_pkg::LERP_DIV)) u_div_lerp (
      .clock (clock),
      .load  (ctl.load[ST_LERP+2:ST_LERP]),
      .num   (lprod_ff),
      .quo   (f_q)
   );

   // ------------------------------------------------- stage 16: blend, output
   function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] f);
      logic [16:0] acc;
      acc = 17'(a) * (17'd256 - 17'(f)) + 17'(b) * 17'(f);
      return acc[15:8];
   endfunction

   logic [7:0]  f_sat;
   logic [23:0] col_a, col_b;
   logic [awpg_pkg::CH_W-1:0] red_ff, green_ff, blue_ff;

   assign f_sat = (f_q > F_Q_W'(awpg_pkg::F_MAX)) ? 8'(awpg_pkg::F_MAX) : f_q[7:0];

   always_comb begin
      unique case (band_pipe_ff[4])
         awpg_pkg::BAND_HIGH: begin
            col_a = awpg_pkg::COL_GREEN;
            col_b = awpg_pkg::COL_PURPLE;
         end
         awpg_pkg::BAND_MID: begin
            col_a = awpg_pkg::COL_BLUE;
            col_b = awpg_pkg::COL_GREEN;
         end
         awpg_pkg::BAND_LOW: begin
            col_a = awpg_pkg::COL_NIGHT;
            col_b = awpg_pkg::COL_BLUE;
         end
         default: begin
            // flat night sky: blending a colour with itself
            col_a = awpg_pkg::COL_NIGHT;
            col_b = awpg_pkg::COL_NIGHT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.load[ST_OUT]) begin
         red_ff   <= lerp8(col_a[23:16], col_b[23:16], f_sat);
         green_ff <= lerp8(col_a[15:8],  col_b[15:8],  f_sat);
         blue_ff  <= lerp8(col_a[7:0],   col_b[7:0],   f_sat);
      end
   end

   assign rsp_ch.red   = red_ff;
   assign rsp_ch.green = green_ff;
   assign rsp_ch.blue  = blue_ff;

endmodule

`default_nettype wire

// ===== tb/sv/awpg_colour_checker.sv =====
// Colour predictor and response scoreboard for the aurora pixel generator.
`timescale 1ns / 100ps

module awpg_colour_checker (
   input  wire logic clock,
   input  wire logic reset,
   awpg_req_if       req_mon,
   awpg_rsp_if       rsp_mon,
   output int        mismatches,
   output int        outstanding
);

   localparam int unsigned FRAME_W  = 1024;
   localparam int unsigned FRAME_H  = 768;
   localparam int          LVL_HIGH = 45875;
   localparam int          LVL_MID  = 26214;
   localparam int          LVL_LOW  = 6553;
   localparam int          REPORT_MAX = 10;

   localparam logic [23:0] RGB_GREEN  = 24'h00FF44;
   localparam logic [23:0] RGB_PURPLE = 24'h8844FF;
   localparam logic [23:0] RGB_BLUE   = 24'h0044FF;
   localparam logic [23:0] RGB_NIGHT  = 24'h000011;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } colour_type;

   logic [14:0] sine_quarter [0:256];
   colour_type  colour_q [$];
   int          miss_count;

   // sin(pi/2 * k/256) at amplitude 32767, Q30 series up to x^17
   function automatic logic [14:0] taylor_sine(input int unsigned k);
      logic [63:0] x;
      logic [63:0] term;
      longint      acc;
      x    = (64'(k) * 64'd3373259426) >> 9;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      if (acc > 64'sd1073741824) begin
         acc = 64'sd1073741824;
      end
      return 15'((64'(acc) * 64'd32767 + 64'd536870912) >> 30);
   endfunction

   initial begin
      miss_count  = 0;
      mismatches  = 0;
      outstanding = 0;
      for (int k = 0; k <= 256; k++) begin
         sine_quarter[k] = taylor_sine(k);
      end
   end

   // Q1.15 sine; phase in 2^-17 half turns, one turn = 2^18
   function automatic int wave_q15(input logic [31:0] ph);
      logic [9:0] idx;
      int         mag;
      idx = ph[17:8];
      mag = idx[8] ? int'(sine_quarter[256 - int'(idx[7:0])])
                   : int'(sine_quarter[idx[7:0]]);
      return idx[9] ? -mag : mag;
   endfunction

   // Attenuated intensity, Q0.16 (0..65536)
   function automatic logic [16:0] pixel_level(input logic [awpg_pkg::PX_W-1:0] px,
                                              input logic [awpg_pkg::PY_W-1:0] py,
                                              input logic [awpg_pkg::T_W-1:0]  t);
      logic [31:0] nx;
      logic [31:0] ny;
      logic [31:0] inten;
      logic [31:0] d;
      logic [31:0] att;
      logic [63:0] v;
      int          s;
      nx    = (32'(px) << 16) / FRAME_W;
      ny    = (32'(py) << 16) / FRAME_H;
      s     = wave_q15(16 * ny + 4 * nx + 4 * 32'(t))
            + wave_q15(24 * ny + 3 * nx + 3 * 32'(t))
            + wave_q15(12 * ny + 6 * nx + 6 * 32'(t));
      inten = 32'((64'(s + 98301) << 16) / 64'd196602);
      d     = (ny >= 32'd65536) ? 32'd0 : 32'd65536 - ny;
      att   = 32'((64'(d) * 64'(d)) >> 16);
      v     = (64'(inten) * 64'(att)) >> 16;
      return v[16:0];
   endfunction

   function automatic int ramp_factor(input logic [16:0] v, input int lvl);
      longint f;
      f = ((longint'(v) - longint'(lvl)) * 333) / 25600;
      return (f > 255) ? 255 : int'(f);
   endfunction

   function automatic logic [23:0] mix_rgb(input logic [23:0] a, input logic [23:0] b,
                                           input int f);
      logic [23:0] rgb;
      int          acc;
      for (int sh = 0; sh < 24; sh += 8) begin
         acc = int'(a[sh +: 8]) * (256 - f) + int'(b[sh +: 8]) * f;
         rgb[sh +: 8] = 8'(acc >> 8);
      end
      return rgb;
   endfunction

   // Level sitting exactly on a threshold drops to the band below
   function automatic logic [23:0] band_colour(input logic [16:0] v);
      if (int'(v) > LVL_HIGH) begin
         return mix_rgb(RGB_GREEN, RGB_PURPLE, ramp_factor(v, LVL_HIGH));
      end
      if (int'(v) > LVL_MID) begin
         return mix_rgb(RGB_BLUE, RGB_GREEN, ramp_factor(v, LVL_MID));
      end
      if (int'(v) > LVL_LOW) begin
         return mix_rgb(RGB_NIGHT, RGB_BLUE, ramp_factor(v, LVL_LOW));
      end
      return RGB_NIGHT;
   endfunction

   always @(posedge clock) begin
      colour_type want;
      colour_type got;
      if (!reset) begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.red, rsp_mon.green, rsp_mon.blue};
            if (colour_q.size() == 0) begin
               miss_count++;
               if (miss_count <= REPORT_MAX) begin
                  $display("%0t: colour beat %h%h%h with nothing pending",
                           $realtime, got.red, got.green, got.blue);
               end
            end else begin
               want = colour_q.pop_front();
               if (got.red !== want.red || got.green !== want.green
                   || got.blue !== want.blue) begin
                  miss_count++;
                  if (miss_count <= REPORT_MAX) begin
                     $display("%0t: colour exp r=%h g=%h b=%h got r=%h g=%h b=%h",
                              $realtime, want.red, want.green, want.blue,
                              got.red, got.green, got.blue);
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            colour_q.push_back(colour_type'(band_colour(
               pixel_level(req_mon.pixel_x, req_mon.pixel_y, req_mon.time_phase))));
         end
      end
      mismatches  <= miss_count;
      outstanding <= colour_q.size();
   end

endmodule

// ===== tb/sv/tb_aurora_wave_pixel_generator_unit.sv =====
// Top of the aurora pixel generator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_aurora_wave_pixel_generator_unit;

   localparam int STALL_PCT     = 21;     // idle share on either side, per cent
   localparam int RANDOM_BEATS  = 1930;
   localparam int QUIET_LIMIT   = 2000;   // cycles without any beat before giving up
   localparam int SETTLE_CYCLES = 40;     // pipeline is 17 deep, so this is ample
   localparam int EDGE_TRIES    = 20000;
   localparam int CALM_FIRST    = 700;    // random beats in this window never idle
   localparam int CALM_LAST     = 1000;
   localparam int DRAIN_AT      = 1300;   // sender holds off here until all colours are back
   localparam int BAND_EDGES [3] = '{6553, 26214, 45875};

   logic clock;
   logic reset;
   logic calm;
   int   mismatches;
   int   outstanding;
   int   quiet_cycles;

   awpg_req_if pix_req();
   awpg_rsp_if pix_rsp();

   aurora_wave_pixel_generator_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (pix_req),
      .rsp_ch (pix_rsp)
   );

   // Watches both channels, predicts each colour and compares it
   awpg_colour_checker colour_chk (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (pix_req),
      .rsp_mon     (pix_rsp),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Colour sink: random back-pressure, none while calm is set
   initial begin
      pix_rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         pix_rsp.ready <= calm || ($urandom_range(99) >= STALL_PCT);
      end
   end

   // Watchdog: too long without any beat on either channel means a hang
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((pix_req.valid && pix_req.ready) || (pix_rsp.valid && pix_rsp.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One pixel beat, with random idle cycles ahead of it unless calm.
   // Valid is only lowered when a gap is actually taken, so back-to-back
   // beats never see a low and a high in the same step.
   task automatic send_pixel(input logic [awpg_pkg::PX_W-1:0] x,
                             input logic [awpg_pkg::PY_W-1:0] y,
                             input logic [awpg_pkg::T_W-1:0]  t);
      while (!calm && $urandom_range(99) < STALL_PCT) begin
         pix_req.valid <= 1'b0;
         @(posedge clock);
      end
      pix_req.valid      <= 1'b1;
      pix_req.pixel_x    <= x;
      pix_req.pixel_y    <= y;
      pix_req.time_phase <= t;
      do @(posedge clock); while (!pix_req.ready);
   endtask

   initial begin
      logic [awpg_pkg::PX_W-1:0] edge_x [6];
      logic [awpg_pkg::PY_W-1:0] edge_y [6];
      logic [awpg_pkg::T_W-1:0]  edge_t [6];
      logic [awpg_pkg::PX_W-1:0] tx;
      logic [awpg_pkg::PY_W-1:0] ty;
      logic [awpg_pkg::T_W-1:0]  tt;
      int                        lvl;
      int                        gap_on;
      int                        gap_over;
      int                        spread;
      int                        pick;

      reset              <= 1'b1;
      calm               <= 1'b0;
      pix_req.valid      <= 1'b0;
      pix_req.pixel_x    <= '0;
      pix_req.pixel_y    <= '0;
      pix_req.time_phase <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Hunt for pixels whose level lands on a band threshold and one above it.
      // Rows near the top keep attenuation low so every band is reachable.
      // No simulation time passes here.
      for (int e = 0; e < 3; e++) begin
         gap_on   = 1 << 30;
         gap_over = 1 << 30;
         for (int n = 0; n < EDGE_TRIES && (gap_on != 0 || gap_over != 0); n++) begin
            tx  = awpg_pkg::PX_W'($urandom);
            ty  = awpg_pkg::PY_W'($urandom_range(40));
            tt  = awpg_pkg::T_W'($urandom);
            lvl = int'(colour_chk.pixel_level(tx, ty, tt));
            spread = lvl - BAND_EDGES[e];
            if (spread < 0) begin
               spread = -spread;
            end
            if (spread < gap_on) begin
               gap_on = spread;
               edge_x[2*e] = tx;
               edge_y[2*e] = ty;
               edge_t[2*e] = tt;
            end
            spread = lvl - BAND_EDGES[e] - 1;
            if (spread < 0) begin
               spread = -spread;
            end
            if (spread < gap_over) begin
               gap_over = spread;
               edge_x[2*e+1] = tx;
               edge_y[2*e+1] = ty;
               edge_t[2*e+1] = tt;
            end
         end
      end

      // Directed: field extremes, alternating bit patterns, the bottom row of
      // the frame, rows beyond the frame (full attenuation) and band edges
      send_pixel(10'd0,    10'd0,    18'd0);
      send_pixel(10'd1023, 10'd0,    18'd0);
      send_pixel(10'd0,    10'd767,  18'd0);
      send_pixel(10'd1023, 10'd767,  18'd262143);
      send_pixel(10'd0,    10'd768,  18'd0);
      send_pixel(10'd1023, 10'd1023, 18'd262143);
      send_pixel(10'd0,    10'd0,    18'd262143);
      send_pixel(10'd512,  10'd384,  18'd131072);
      send_pixel(10'h2AA,  10'h155,  18'h2AAAA);
      send_pixel(10'h155,  10'h2AA,  18'h15555);
      send_pixel(10'd1023, 10'd1,    18'd65536);
      for (int k = 0; k < 6; k++) begin
         send_pixel(edge_x[k], edge_y[k], edge_t[k]);
      end

      // Random: mostly inside the frame, a share of rows near the top where
      // the bright bands live, and some rows past the bottom edge
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         calm <= (n >= CALM_FIRST && n < CALM_LAST);
         if (n == DRAIN_AT) begin
            pix_req.valid <= 1'b0;
            do @(posedge clock); while (outstanding != 0);
         end
         pick = $urandom_range(99);
         tx   = awpg_pkg::PX_W'($urandom);
         tt   = awpg_pkg::T_W'($urandom);
         if (pick < 60) begin
            ty = awpg_pkg::PY_W'($urandom_range(767));
         end else if (pick < 85) begin
            ty = awpg_pkg::PY_W'($urandom_range(160));
         end else begin
            ty = awpg_pkg::PY_W'($urandom_range(1023, 768));
         end
         send_pixel(tx, ty, tt);
      end

      // Drain, then give the pipeline time to show any stray beat
      pix_req.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/awpg_pkg.sv
rtl/core/awpg_if.sv
rtl/core/awpg_cdiv.sv
rtl/core/awpg_wave.sv
rtl/core/awpg_ctl.sv
rtl/core/aurora_wave_pixel_generator_unit.sv
tb/sv/awpg_colour_checker.sv
tb/sv/tb_aurora_wave_pixel_generator_unit.sv
